@@ hw/rtl/integer_stack_with_dedup_unit_macros.svh @@
// Assertion macros shared by the stack checker
`ifndef INTEGER_STACK_WITH_DEDUP_UNIT_MACROS_SVH
`define INTEGER_STACK_WITH_DEDUP_UNIT_MACROS_SVH

// check prop at each rising clock edge outside reset
`define ISD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("stack unit check failed");

// check prop at each rising clock edge, reset included
`define ISD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("stack unit reset check failed");

`endif

@@ hw/rtl/isd_pkg.sv @@
// Types, constants and codes of the integer stack with dedup unit
package isd_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;
  localparam int FILL_W = 6;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 48;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEDUP = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_DRD   = 6'b000100,
    S_DCAP  = 6'b001000,
    S_DSCAN = 6'b010000,
    S_DWR   = 6'b100000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] top_value;
    logic [ST_W-1:0]          status;
  } res_t;

endpackage

@@ hw/rtl/isd_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module isd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/isd_core.sv @@
// Command sequencer: stack pointer, top read and duplicate removal walk
module isd_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [isd_pkg::CMD_W-1:0]    cmd,
  input  logic [isd_pkg::DATA_W-1:0]   push_value,
  input  logic                         slot_free,
  output isd_pkg::mem_req_t            mem_req,
  input  logic [isd_pkg::DATA_W-1:0]   mem_rdata,
  output logic                         res_valid,
  output isd_pkg::res_t                res
);
  import isd_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  i_idx, i_idx_next;
  logic [CNT_W-1:0]  kept, kept_next;
  logic [CNT_W-1:0]  j_idx, j_idx_next;
  logic [DATA_W-1:0] v, v_next;
  logic              cmp_valid, cmp_valid_next;
  logic              in_fire;
  logic              hit;
  logic              last_i;

  assign in_ready = (state == S_IDLE) && slot_free;
  assign in_fire  = in_valid && in_ready;
  assign hit      = cmp_valid && (mem_rdata == v);
  assign last_i   = (i_idx == (count - 1'b1));

  always_comb begin
    state_next     = state;
    count_next     = count;
    i_idx_next     = i_idx;
    kept_next      = kept;
    j_idx_next     = j_idx;
    v_next         = v;
    cmp_valid_next = cmp_valid;
    res_valid      = 1'b0;
    res.status     = ST_OK;
    res.top_value  = '0;
    mem_req.we     = 1'b0;
    mem_req.waddr  = '0;
    mem_req.wdata  = push_value;
    mem_req.raddr  = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_PUSH: begin
              res_valid = 1'b1;
              if (count >= CNT_W'(DEPTH)) begin
                res.status = ST_OVERFLOW;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ADDR_W'(count);
                count_next    = count + 1'b1;
              end
            end
            CMD_POP: begin
              res_valid = 1'b1;
              if (count == '0) begin
                res.status = ST_UNDERFLOW;
              end else begin
                count_next = count - 1'b1;
              end
            end
            CMD_READ: begin
              if (count == '0) begin
                res_valid  = 1'b1;
                res.status = ST_UNDERFLOW;
              end else begin
                mem_req.raddr = ADDR_W'(count - 1'b1);
                state_next    = S_READ;
              end
            end
            CMD_CLEAR: begin
              res_valid  = 1'b1;
              count_next = '0;
            end
            CMD_DEDUP: begin
              if (count == '0) begin
                res_valid = 1'b1;
              end else begin
                i_idx_next = '0;
                kept_next  = '0;
                state_next = S_DRD;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_valid     = 1'b1;
        res.top_value = mem_rdata;
        state_next    = S_IDLE;
      end
      S_DRD: begin
        mem_req.raddr = ADDR_W'(i_idx);
        state_next    = S_DCAP;
      end
      S_DCAP: begin
        v_next         = mem_rdata;
        j_idx_next     = '0;
        cmp_valid_next = 1'b0;
        state_next     = S_DSCAN;
      end
      S_DSCAN: begin
        if (hit) begin
          cmp_valid_next = 1'b0;
          i_idx_next     = i_idx + 1'b1;
          if (last_i) begin
            count_next = kept;
            res_valid  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_DRD;
          end
        end else if (j_idx < kept) begin
          mem_req.raddr  = ADDR_W'(j_idx);
          j_idx_next     = j_idx + 1'b1;
          cmp_valid_next = 1'b1;
        end else begin
          cmp_valid_next = 1'b0;
          state_next     = S_DWR;
        end
      end
      S_DWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(kept);
        mem_req.wdata = v;
        kept_next     = kept + 1'b1;
        i_idx_next    = i_idx + 1'b1;
        if (last_i) begin
          count_next = kept + 1'b1;
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.is_empty   = (count_next == '0);
    res.fill_count = FILL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    i_idx <= i_idx_next;
    kept  <= kept_next;
    j_idx <= j_idx_next;
    v     <= v_next;
  end

endmodule

@@ hw/rtl/integer_stack_with_dedup_unit.sv @@
// Push, pop, clear and unused codes are answered from the idle state; read top waits on one
// RAM read. Remove duplicates is a walk that compares each entry against the kept ones
// through the single RAM read port.
// Throughput: one command in flight; next transfer accepted when the sequencer is idle
// and the output register is free or being taken. Synchronous active-high reset empties
// the stack and drops any pending result; RAM contents are left as they are.
module integer_stack_with_dedup_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [isd_pkg::IN_W-1:0]  s_tdata,   // [2:0] cmd, [34:3] push_value, [39:35] zero
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [isd_pkg::OUT_W-1:0] m_tdata    // [1:0] status, [33:2] top_value,
                                               // [34] is_empty, [40:35] fill_count,
                                               // [47:41] zero
);
  import isd_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  res_t              res;
  logic              slot_free;

  assign slot_free = !m_tvalid || m_tready;

  isd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cmd        (s_tdata[CMD_W-1:0]),
    .push_value (s_tdata[CMD_W+DATA_W-1:CMD_W]),
    .slot_free  (slot_free),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  isd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= OUT_W'(res);
    end
  end

endmodule

@@ hw/rtl/isd_checker.sv @@
// Port-level checks of the stack unit, bound to the top level
`include "integer_stack_with_dedup_unit_macros.svh"

module isd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [isd_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [isd_pkg::OUT_W-1:0] m_tdata
);
  import isd_pkg::*;

  logic [ST_W-1:0]   o_status;
  logic [DATA_W-1:0] o_top;
  logic              o_empty;
  logic [FILL_W-1:0] o_fill;

  assign o_status = m_tdata[1:0];
  assign o_top    = m_tdata[33:2];
  assign o_empty  = m_tdata[34];
  assign o_fill   = m_tdata[40:35];

  `ISD_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid)
  `ISD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `ISD_ASSERT(a_empty_matches_fill, m_tvalid |-> (o_empty == (o_fill == '0)))
  `ISD_ASSERT(a_top_zero_on_error, m_tvalid && (o_status != ST_OK) |-> (o_top == '0))
  `ISD_ASSERT(a_status_code, m_tvalid |-> (o_status <= ST_OVERFLOW))

endmodule

bind integer_stack_with_dedup_unit isd_checker u_isd_checker (.*);

@@ bench/testbench.sv @@
// Self-checking bench for the integer stack with dedup unit: random command streams
`timescale 1ns / 1ps

module testbench;
  import isd_pkg::*;

  localparam int LIMIT = 4_000_000;
  localparam int ITEMS = 1650;
  localparam logic [CMD_W-1:0] CMD_LAST = '1;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_ALL_ONES = -1;

  class lifo_scoreboard;
    logic signed [DATA_W-1:0] entries[DEPTH];
    int unsigned held;
    res_t awaited[$];
    int unsigned faults;

    function new();
      held = 0;
      faults = 0;
    endfunction

    function void squeeze_duplicates();
      int unsigned kept;
      bit seen;
      kept = 0;
      for (int unsigned i = 0; i < held; i++) begin
        seen = 0;
        for (int unsigned j = 0; j < kept; j++)
          if (entries[j] == entries[i]) seen = 1;
        if (!seen) begin
          entries[kept] = entries[i];
          kept++;
        end
      end
      held = kept;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
      res_t r;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (held >= DEPTH) begin
            r.status = ST_OVERFLOW;
          end else begin
            entries[held] = value;
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) r.status = ST_UNDERFLOW;
          else held--;
        end
        CMD_READ: begin
          if (held == 0) r.status = ST_UNDERFLOW;
          else r.top_value = entries[held-1];
        end
        CMD_CLEAR: held = 0;
        CMD_DEDUP: squeeze_duplicates();
        default: ;
      endcase
      r.is_empty = (held == 0);
      r.fill_count = held[FILL_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("result with no command outstanding: %h", got);
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        faults++;
      end
      if (got.top_value !== want.top_value) begin
        $error("top_value: expected %0d, actual %0d", want.top_value, got.top_value);
        faults++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
        faults++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
        faults++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  lifo_scoreboard sb;
  int unsigned cycles;
  int unsigned commands_sent;
  int unsigned sink_hold;
  bit          sink_calm;
  bit          source_calm;
  logic signed [DATA_W-1:0] value_pool[4];

  integer_stack_with_dedup_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // check output first: the expectation it consumes is always older than a new command
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(res_t'(m_tdata[40:0]));
      if (s_tvalid && s_tready)
        sb.note_command(s_tdata[CMD_W-1:0], s_tdata[CMD_W+DATA_W-1:CMD_W]);
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 499) == 0) sink_calm = !sink_calm;
    if (sink_hold > 0) begin
      m_tready = 1'b0;
      sink_hold--;
    end else begin
      m_tready = 1'b1;
      if (!sink_calm && $urandom_range(0, 99) < 30) sink_hold = stall_len();
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
    int unsigned gap;
    gap = (source_calm || $urandom_range(0, 99) < 50) ? 0 : stall_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata = IN_W'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {{(IN_W-CMD_W-DATA_W){1'b0}}, value, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (cmd <= CMD_DEDUP) commands_sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return value_pool[$urandom_range(0, 3)];
    if (r < 50) return (r[0]) ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  task automatic push_burst(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_command(CMD_PUSH, pick_value());
  endtask

  task automatic random_phase();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    source_calm = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 3) == 0)
      foreach (value_pool[k]) value_pool[k] = $urandom;
    if (kind < 35) begin
      push_burst($urandom_range(1, 12));
      send_command(CMD_READ, $urandom);
    end else if (kind < 55) begin
      n = $urandom_range(1, 10);
      for (int unsigned i = 0; i < n; i++)
        send_command($urandom_range(0, 1) ? CMD_POP : CMD_READ, $urandom);
    end else if (kind < 65) begin
      while (sb.held < DEPTH) send_command(CMD_PUSH, pick_value());
      push_burst($urandom_range(1, 3));
      send_command(CMD_READ, $urandom);
      send_command(CMD_DEDUP, $urandom);
      send_command(CMD_READ, $urandom);
    end else if (kind < 77) begin
      send_command(CMD_DEDUP, $urandom);
      send_command(CMD_READ, $urandom);
    end else if (kind < 82) begin
      send_command(CMD_CLEAR, $urandom);
    end else if (kind < 86) begin
      send_command(CMD_W'($urandom_range(CMD_DEDUP + 1, CMD_LAST)), $urandom);
    end else begin
      n = $urandom_range(1, 6);
      for (int unsigned i = 0; i < n; i++) send_command(CMD_W'($urandom), pick_value());
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    commands_sent = 0;
    sink_hold = 0;
    sink_calm = 1'b0;
    source_calm = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    foreach (value_pool[k]) value_pool[k] = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_command(CMD_POP, '0);
    send_command(CMD_READ, '0);
    send_command(CMD_DEDUP, '0);
    send_command(CMD_CLEAR, '0);
    send_command(CMD_PUSH, VAL_MIN);
    send_command(CMD_PUSH, VAL_MAX);
    send_command(CMD_PUSH, '0);
    send_command(CMD_PUSH, VAL_ALL_ONES);
    send_command(CMD_PUSH, VAL_MAX);
    send_command(CMD_PUSH, VAL_MIN);
    send_command(CMD_READ, '0);
    send_command(CMD_DEDUP, '0);
    send_command(CMD_READ, '0);
    send_command(CMD_POP, VAL_ALL_ONES);
    send_command(CMD_READ, VAL_ALL_ONES);
    for (logic [CMD_W:0] c = {1'b0, CMD_DEDUP} + 1'b1; c <= CMD_LAST; c++)
      send_command(c[CMD_W-1:0], VAL_ALL_ONES);
    send_command(CMD_CLEAR, '0);
    send_command(CMD_READ, '0);
    send_command(CMD_DEDUP, '0);

    while (commands_sent < ITEMS) random_phase();
    s_tvalid = 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.faults == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
